>>> design/oat_pkg.sv
// Shared types and constants for the ordered array table.
// No dependencies; every other file in this block imports this package.
package oat_pkg;

  // Table geometry and field widths.
  localparam int DEPTH  = 64;
  localparam int WORD_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  // Gather tree: the first stage covers groups of GRP cells.
  localparam int GRP    = 8;
  localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
  localparam int GRP_W  = $clog2(GRP);

  // Stream packing widths (whole bytes).
  localparam int IN_BITS  = CMD_W + IDX_W + WORD_W + CNT_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = WORD_W + IDX_W + STAT_W + CNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Command codes carried by an input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_WRITE  = 3'd4,
    CMD_FIND   = 3'd5,
    CMD_ROT_R  = 3'd6,
    CMD_ROT_L  = 3'd7
  } cmd_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD      = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_APPEND,
    OP_INSERT,
    OP_REMOVE,
    OP_WRITE,
    OP_ROT_R,
    OP_ROT_L
  } cell_op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_GATHER,
    S_APPLY,
    S_ROTATE,
    S_DONE
  } state_t;

  // Control bundle shared by all cells.
  typedef struct packed {
    cell_op_t           op;
    logic [CNT_W-1:0]   pos;
    logic [CNT_W-1:0]   count;
    logic [WORD_W-1:0]  operand;
    logic [CNT_W-1:0]   rd_addr;
    logic [WORD_W-1:0]  key;
  } cell_ctl_t;

endpackage

>>> design/ordered_array_table_unit.sv
// Ordered array table: top level with sequencer, cell chain and gather tree.
// Depends on oat_pkg, oat_cell and oat_gather.
//
// Usage:
//   The in_ channel carries one command item (append, insert, remove, read,
//   write, find, rotate right, rotate left). The out_ channel returns exactly
//   one result item per command, with the read or removed word, the find
//   position, a status code and the table length after the command.
//   Entries live in a chain of cells, one word per cell; insert, remove and
//   rotations shift all cells at once through their neighbor links.
//   Every command passes through a gather, an apply and a done step after
//   acceptance; rotate left on a non-empty table adds a rotate step in which
//   the chain rotates left by one position per cycle, and stepping rotate_count
//   times over the live entries gives the count taken modulo the length. The
//   block works on one item at a time; a new item is taken once the previous
//   one has reached the output register. When the receiver stalls, the
//   finished result waits in the output register and the next item waits in
//   its final step until the register is free. Reset clears all entries and
//   the length to zero and drops any pending result.
module ordered_array_table_unit import oat_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // in_tdata: cmd[2:0], position[8:3], word_in[40:9], rotate_count[47:41]
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  // out_tdata: word_out[31:0], found_position[37:32], status[39:38],
  //            length[46:40], zero fill[47]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  // Input field unpacking.
  localparam int POS_LO = CMD_W;
  localparam int WRD_LO = POS_LO + IDX_W;
  localparam int ROT_LO = WRD_LO + WORD_W;

  logic              in_fire;
  logic [CMD_W-1:0]  in_cmd;
  logic [IDX_W-1:0]  in_position;
  logic [WORD_W-1:0] in_word;
  logic [CNT_W-1:0]  in_rotate_count;

  assign in_cmd          = in_tdata[CMD_W-1:0];
  assign in_position     = in_tdata[WRD_LO-1:POS_LO];
  assign in_word         = in_tdata[ROT_LO-1:WRD_LO];
  assign in_rotate_count = in_tdata[ROT_LO+CNT_W-1:ROT_LO];

  // Sequencer and command registers.
  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [IDX_W-1:0]  pos_r;
  logic [WORD_W-1:0] word_r;
  logic [CNT_W-1:0]  rcnt_r, rcnt_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // Pending result and output register.
  logic [WORD_W-1:0] res_word_r, res_word_nxt;
  logic [IDX_W-1:0]  res_fpos_r, res_fpos_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r;
  logic              out_free;
  logic              apply_rotate;

  // Chain and gather signals.
  cell_ctl_t         ctl;
  cell_op_t          apply_op;
  logic [WORD_W-1:0] cell_data [DEPTH];
  logic [WORD_W-1:0] tap_data  [DEPTH];
  logic [DEPTH-1:0]  tap_match;
  logic [WORD_W-1:0] rd_word;
  logic              hit_any;
  logic [IDX_W-1:0]  hit_idx;
  logic [CNT_W-1:0]  pos_ext;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign pos_ext  = {1'b0, pos_r};

  // Command decode in the apply step: status, result word and new length.
  always_comb begin
    apply_op       = OP_HOLD;
    apply_rotate   = 1'b0;
    res_word_nxt   = '0;
    res_fpos_nxt   = '0;
    res_status_nxt = ST_OK;
    count_nxt      = count_r;
    unique case (cmd_r)
      CMD_APPEND: begin
        if (count_r == CNT_W'(DEPTH)) begin
          res_status_nxt = ST_FULL;
        end else begin
          apply_op  = OP_APPEND;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_INSERT: begin
        priority if (count_r == CNT_W'(DEPTH)) begin
          res_status_nxt = ST_FULL;
        end else if (pos_ext > count_r) begin
          res_status_nxt = ST_BAD;
        end else begin
          apply_op  = OP_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (pos_ext >= count_r) begin
          res_status_nxt = ST_BAD;
        end else begin
          apply_op     = OP_REMOVE;
          res_word_nxt = rd_word;
          count_nxt    = count_r - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (pos_ext >= count_r) begin
          res_status_nxt = ST_BAD;
        end else begin
          res_word_nxt = rd_word;
        end
      end
      CMD_WRITE: begin
        if (pos_ext >= count_r) begin
          res_status_nxt = ST_BAD;
        end else begin
          apply_op = OP_WRITE;
        end
      end
      CMD_FIND: begin
        if (hit_any) begin
          res_fpos_nxt = hit_idx;
        end else begin
          res_status_nxt = ST_NOTFOUND;
        end
      end
      CMD_ROT_R: begin
        if (count_r == '0) begin
          res_status_nxt = ST_BAD;
        end else begin
          apply_op = OP_ROT_R;
        end
      end
      CMD_ROT_L: begin
        if (count_r == '0) begin
          res_status_nxt = ST_BAD;
        end else begin
          apply_rotate = 1'b1;
        end
      end
      default: begin
        apply_op = OP_HOLD;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_GATHER;
      S_GATHER: state_nxt = S_APPLY;
      S_APPLY:  state_nxt = apply_rotate ? S_ROTATE : S_DONE;
      S_ROTATE: if (rcnt_r == '0) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // State outputs: chain control, rotate counter and output register load.
  always_comb begin
    in_tready     = 1'b0;
    ctl.op        = OP_HOLD;
    ctl.pos       = pos_ext;
    ctl.count     = count_r;
    ctl.operand   = (cmd_r == CMD_ROT_R) ? rd_word : word_r;
    ctl.rd_addr   = (cmd_r == CMD_ROT_R) ? (count_r - CNT_W'(1)) : pos_ext;
    ctl.key       = word_r;
    rcnt_nxt      = rcnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_GATHER: begin
        ctl.op = OP_HOLD;
      end
      S_APPLY: begin
        ctl.op = apply_op;
      end
      S_ROTATE: begin
        if (rcnt_r != '0) begin
          ctl.op   = OP_ROT_L;
          rcnt_nxt = rcnt_r - CNT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_APPLY) count_r <= count_nxt;
    end
  end

  // Payload registers: command capture, pending result, output data.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= cmd_t'(in_cmd);
      pos_r  <= in_position;
      word_r <= in_word;
    end
    if (in_fire) begin
      rcnt_r <= in_rotate_count;
    end else begin
      rcnt_r <= rcnt_nxt;
    end
    if (state_r == S_APPLY) begin
      res_word_r   <= res_word_nxt;
      res_fpos_r   <= res_fpos_nxt;
      res_status_r <= res_status_nxt;
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r <= OUT_W'({count_r, res_status_r, res_fpos_r, res_word_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Chain of cells; the ends see zero beyond the table.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_in;
    logic [WORD_W-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end

    oat_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (CNT_W'(i)),
      .ctl        (ctl),
      .left_data  (left_in),
      .right_data (right_in),
      .head_data  (cell_data[0]),
      .data_out   (cell_data[i]),
      .tap_data   (tap_data[i]),
      .tap_match  (tap_match[i])
    );
  end

  // Read and search results, registered once while the chain holds.
  oat_gather u_gather (
    .clk       (clk),
    .en        (state_r == S_GATHER),
    .tap_data  (tap_data),
    .tap_match (tap_match),
    .rd_word   (rd_word),
    .hit_any   (hit_any),
    .hit_idx   (hit_idx)
  );

  // The length never exceeds the table depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(DEPTH))
    else $error("table length above depth");

  // An accepted item always moves the sequencer into its gather step.
  assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> state_r == S_GATHER)
    else $error("accepted item did not start gathering");

  // The length changes only in the apply step.
  assert property (@(posedge clk) disable iff (!rst_n)
                   state_r != S_APPLY |=> $stable(count_r))
    else $error("length changed outside the apply step");

  // A full status is reported only with a full table.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_tvalid && out_tdata[39:38] == ST_FULL)
                   |-> out_tdata[46:40] == CNT_W'(DEPTH))
    else $error("full status with a table that is not full");

endmodule

>>> design/oat_cell.sv
// One storage cell of the table chain: holds one entry and trades it with its neighbors.
// Depends on oat_pkg.
module oat_cell import oat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  cell_idx,
  input  cell_ctl_t         ctl,
  input  logic [WORD_W-1:0] left_data,
  input  logic [WORD_W-1:0] right_data,
  input  logic [WORD_W-1:0] head_data,
  output logic [WORD_W-1:0] data_out,
  output logic [WORD_W-1:0] tap_data,
  output logic              tap_match
);

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;
  logic [CNT_W-1:0]  last_idx;

  assign last_idx = ctl.count - CNT_W'(1);

  // Pick the new content of this cell from the broadcast operation.
  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      OP_HOLD: begin
        data_nxt = data_r;
      end
      OP_APPEND: begin
        if (cell_idx == ctl.count) data_nxt = ctl.operand;
      end
      OP_INSERT: begin
        if (cell_idx == ctl.pos) begin
          data_nxt = ctl.operand;
        end else if (cell_idx > ctl.pos && cell_idx <= ctl.count) begin
          data_nxt = left_data;
        end
      end
      OP_REMOVE: begin
        if (cell_idx >= ctl.pos && cell_idx < last_idx) begin
          data_nxt = right_data;
        end else if (cell_idx == last_idx) begin
          data_nxt = '0;
        end
      end
      OP_WRITE: begin
        if (cell_idx == ctl.pos) data_nxt = ctl.operand;
      end
      OP_ROT_R: begin
        if (cell_idx == '0) begin
          data_nxt = ctl.operand;
        end else if (cell_idx < ctl.count) begin
          data_nxt = left_data;
        end
      end
      OP_ROT_L: begin
        if (cell_idx < last_idx) begin
          data_nxt = right_data;
        end else if (cell_idx == last_idx) begin
          data_nxt = head_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // Entry register, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  // Read tap and search match for the gather tree.
  assign data_out  = data_r;
  assign tap_data  = (cell_idx == ctl.rd_addr) ? data_r : '0;
  assign tap_match = (cell_idx < ctl.count) && (data_r == ctl.key);

endmodule

>>> design/oat_gather.sv
// Two-stage gather tree: merges the cell read taps and finds the first search match.
// Depends on oat_pkg.
module oat_gather import oat_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] tap_data  [DEPTH],
  input  logic [DEPTH-1:0]  tap_match,
  output logic [WORD_W-1:0] rd_word,
  output logic              hit_any,
  output logic [IDX_W-1:0]  hit_idx
);

  logic [WORD_W-1:0] grp_word_r [NGRP];
  logic [WORD_W-1:0] grp_word_nxt [NGRP];
  logic [NGRP-1:0]   grp_any_r;
  logic [NGRP-1:0]   grp_any_nxt;
  logic [GRP_W-1:0]  grp_loc_r [NGRP];
  logic [GRP_W-1:0]  grp_loc_nxt [NGRP];

  // First stage: OR the taps and find the lowest match inside each group.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_word_nxt[g] = '0;
      grp_any_nxt[g]  = 1'b0;
      grp_loc_nxt[g]  = '0;
      for (int l = GRP - 1; l >= 0; l--) begin
        if (g * GRP + l < DEPTH) begin
          grp_word_nxt[g] = grp_word_nxt[g] | tap_data[g * GRP + l];
          if (tap_match[g * GRP + l]) begin
            grp_any_nxt[g] = 1'b1;
            grp_loc_nxt[g] = GRP_W'(l);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_word_r <= grp_word_nxt;
      grp_any_r  <= grp_any_nxt;
      grp_loc_r  <= grp_loc_nxt;
    end
  end

  // Second stage: merge the groups, the lowest matching group wins.
  always_comb begin
    rd_word = '0;
    hit_any = 1'b0;
    hit_idx = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      rd_word = rd_word | grp_word_r[g];
      if (grp_any_r[g]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(g * GRP) + IDX_W'(grp_loc_r[g]);
      end
    end
  end

endmodule

>>> dv/tb_ordered_array_table_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for ordered_array_table_unit: directed rows, then random traffic.
// Depends on oat_pkg and the RTL of the ordered array table.
module tb_ordered_array_table_unit;
  import oat_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD    = 200;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 100;
  localparam int MAX_REPORTS  = 10;

  // Random command mixes.
  localparam int MIX_GROW   = 0;
  localparam int MIX_EVEN   = 1;
  localparam int MIX_SHRINK = 2;

  // One input item, as the block sees it.
  typedef struct packed {
    cmd_t                     cmd;
    logic [IDX_W-1:0]         pos;
    logic signed [WORD_W-1:0] word;
    logic [CNT_W-1:0]         rcount;
  } table_cmd_t;

  // One result item.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  fpos;
    status_t           status;
    logic [CNT_W-1:0]  len;
  } table_result_t;

  // A directed row; typed rows carry a hand-written expectation.
  typedef struct {
    table_cmd_t    c;
    bit            typed;
    table_result_t want;
  } directed_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  // Shadow copy of the table contents and its length.
  logic [WORD_W-1:0] tbl_words [DEPTH];
  int unsigned       tbl_len;

  table_result_t pending_results [$];
  directed_row_t directed_rows [$];

  int error_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;

  ordered_array_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock and the single reset pulse.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Run limit.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Applies one command to the shadow table and returns the result it gives.
  function automatic table_result_t apply_table_command(table_cmd_t c);
    table_result_t     r;
    int unsigned       n;
    int unsigned       k;
    int                i;
    bit                hit;
    logic [WORD_W-1:0] last;
    logic [WORD_W-1:0] rotated [DEPTH];
    r = '0;
    r.status = ST_OK;
    n = tbl_len;
    hit = 1'b0;
    case (c.cmd)
      CMD_APPEND: begin
        if (n >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tbl_words[n] = c.word;
          tbl_len = n + 1;
        end
      end
      CMD_INSERT: begin
        // The full check wins over the index check.
        if (n >= DEPTH) begin
          r.status = ST_FULL;
        end else if (c.pos > n) begin
          r.status = ST_BAD;
        end else begin
          for (i = n; i > c.pos; i--) tbl_words[i] = tbl_words[i-1];
          tbl_words[c.pos] = c.word;
          tbl_len = n + 1;
        end
      end
      CMD_REMOVE: begin
        if (c.pos >= n) begin
          r.status = ST_BAD;
        end else begin
          r.word = tbl_words[c.pos];
          for (i = c.pos; i + 1 < n; i++) tbl_words[i] = tbl_words[i+1];
          tbl_words[n-1] = '0;
          tbl_len = n - 1;
        end
      end
      CMD_READ: begin
        if (c.pos >= n) r.status = ST_BAD;
        else r.word = tbl_words[c.pos];
      end
      CMD_WRITE: begin
        if (c.pos >= n) r.status = ST_BAD;
        else tbl_words[c.pos] = c.word;
      end
      CMD_FIND: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < n; i++) begin
          if (!hit && tbl_words[i] == c.word) begin
            hit = 1'b1;
            r.fpos = IDX_W'(i);
            r.status = ST_OK;
          end
        end
      end
      CMD_ROT_R: begin
        if (n == 0) begin
          r.status = ST_BAD;
        end else begin
          last = tbl_words[n-1];
          for (i = n - 1; i > 0; i--) tbl_words[i] = tbl_words[i-1];
          tbl_words[0] = last;
        end
      end
      default: begin
        // Left rotation by the count taken modulo the length.
        if (n == 0) begin
          r.status = ST_BAD;
        end else begin
          k = c.rcount % n;
          if (k != 0) begin
            for (i = 0; i < n; i++) rotated[i] = tbl_words[(i + k) % n];
            for (i = 0; i < n; i++) tbl_words[i] = rotated[i];
          end
        end
      end
    endcase
    r.len = CNT_W'(tbl_len);
    return r;
  endfunction

  // Builds a random command; the mix steers the length up, down or neither.
  function automatic table_cmd_t random_command(int mix);
    table_cmd_t       c;
    logic [6:0][7:0]  cut;
    int unsigned      n;
    int               roll;
    int               k;
    n = tbl_len;
    case (mix)
      MIX_GROW: cut = {8'd97, 8'd94, 8'd91, 8'd88, 8'd85, 8'd80, 8'd45};
      MIX_EVEN: cut = {8'd92, 8'd84, 8'd72, 8'd60, 8'd45, 8'd30, 8'd15};
      default:  cut = {8'd94, 8'd88, 8'd78, 8'd70, 8'd60, 8'd10, 8'd5};
    endcase
    roll = $urandom_range(0, 99);
    c.cmd = CMD_ROT_L;
    for (k = 6; k >= 0; k--) begin
      if (roll < cut[k]) c.cmd = cmd_t'(k);
    end
    // Mostly legal positions, some anywhere in the field.
    if ($urandom_range(0, 99) < 20) begin
      c.pos = IDX_W'($urandom_range(0, 63));
    end else if (c.cmd == CMD_INSERT) begin
      c.pos = IDX_W'($urandom_range(0, (n > 63) ? 63 : n));
    end else begin
      c.pos = (n == 0) ? '0 : IDX_W'($urandom_range(0, n - 1));
    end
    // Words: copies of live entries so finds hit, extremes, or anything.
    roll = $urandom_range(0, 99);
    if (roll < 30 && n > 0) begin
      c.word = tbl_words[$urandom_range(0, n - 1)];
    end else if (roll < 40) begin
      case ($urandom_range(0, 3))
        0:       c.word = 32'h0000_0000;
        1:       c.word = 32'hFFFF_FFFF;
        2:       c.word = 32'h7FFF_FFFF;
        default: c.word = 32'h8000_0000;
      endcase
    end else begin
      c.word = $urandom;
    end
    c.rcount = CNT_W'($urandom_range(0, 64));
    return c;
  endfunction

  task automatic add_row(input cmd_t cmd, input int pos, input logic [WORD_W-1:0] word,
                         input int rcount, input bit typed, input logic [WORD_W-1:0] wword,
                         input status_t wstatus, input int wlen);
    directed_row_t row;
    row.c.cmd       = cmd;
    row.c.pos       = IDX_W'(pos);
    row.c.word      = word;
    row.c.rcount    = CNT_W'(rcount);
    row.typed       = typed;
    row.want.word   = wword;
    row.want.fpos   = '0;
    row.want.status = wstatus;
    row.want.len    = CNT_W'(wlen);
    directed_rows   = {directed_rows, row};
  endtask

  // Offers one item, waits for acceptance and records what it should give.
  // Called and left at a falling edge; in_tvalid stays high between items unless an idle gap drops it.
  task automatic send_command(input table_cmd_t c, input bit typed,
                              input table_result_t want);
    table_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {c.rcount, c.word, c.pos, c.cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = apply_table_command(c);
    pending_results = {pending_results, (typed ? want : pred)};
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Result checker: each accepted item against the oldest expectation.
  always @(posedge clk) begin : result_check
    table_result_t got;
    table_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.word   = out_tdata[31:0];
      got.fpos   = out_tdata[37:32];
      got.status = status_t'(out_tdata[39:38]);
      got.len    = out_tdata[46:40];
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("Unexpected result item: word %h pos %0d status %0d len %0d",
                   got.word, got.fpos, got.status, got.len);
      end else begin
        want = pending_results.pop_front();
        if (got.word !== want.word || got.fpos !== want.fpos ||
            got.status !== want.status || got.len !== want.len) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("Mismatch: want w %h p %0d s %0d l %0d, got w %h p %0d s %0d l %0d",
                     want.word, want.fpos, want.status, want.len,
                     got.word, got.fpos, got.status, got.len);
        end
      end
    end
  end

  // Stimulus: directed rows, then random phases with different idling.
  initial begin : stimulus
    int phase;
    int n;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    tbl_len        = 0;
    foreach (tbl_words[i]) tbl_words[i] = '0;

    // Empty table: every indexed command and both rotations fail.
    add_row(CMD_READ,   0,  32'h0,         0,  1, 32'h0, ST_BAD,      0);
    add_row(CMD_REMOVE, 0,  32'h0,         0,  1, 32'h0, ST_BAD,      0);
    add_row(CMD_WRITE,  0,  32'h1234_5678, 0,  1, 32'h0, ST_BAD,      0);
    add_row(CMD_FIND,   0,  32'h0,         0,  1, 32'h0, ST_NOTFOUND, 0);
    add_row(CMD_ROT_R,  0,  32'h0,         0,  1, 32'h0, ST_BAD,      0);
    add_row(CMD_ROT_L,  0,  32'h0,         64, 1, 32'h0, ST_BAD,      0);
    add_row(CMD_INSERT, 1,  32'h0,         0,  1, 32'h0, ST_BAD,      0);
    // Grow with the word extremes; insert at the front and at the length.
    add_row(CMD_APPEND, 0,  32'h7FFF_FFFF, 0,  1, 32'h0, ST_OK,       1);
    add_row(CMD_APPEND, 0,  32'h8000_0000, 0,  1, 32'h0, ST_OK,       2);
    add_row(CMD_INSERT, 0,  32'hFFFF_FFFF, 0,  1, 32'h0, ST_OK,       3);
    add_row(CMD_INSERT, 3,  32'h0,         0,  1, 32'h0, ST_OK,       4);
    add_row(CMD_INSERT, 63, 32'h1,         0,  1, 32'h0, ST_BAD,      4);
    add_row(CMD_READ,   63, 32'h0,         0,  1, 32'h0, ST_BAD,      4);
    // Content-dependent rows go through the predictor.
    add_row(CMD_READ,   0,  32'h0,         0,  0, 32'h0, ST_OK,       0);
    add_row(CMD_WRITE,  1,  32'h5555_5555, 0,  0, 32'h0, ST_OK,       0);
    add_row(CMD_FIND,   0,  32'h8000_0000, 0,  0, 32'h0, ST_OK,       0);
    add_row(CMD_FIND,   0,  32'hDEAD_BEEF, 0,  0, 32'h0, ST_OK,       0);
    add_row(CMD_ROT_R,  0,  32'h0,         0,  0, 32'h0, ST_OK,       0);
    add_row(CMD_ROT_L,  0,  32'h0,         0,  0, 32'h0, ST_OK,       0);
    add_row(CMD_ROT_L,  0,  32'h0,         64, 0, 32'h0, ST_OK,       0);
    add_row(CMD_ROT_L,  0,  32'h0,         7,  0, 32'h0, ST_OK,       0);
    add_row(CMD_REMOVE, 0,  32'h0,         0,  0, 32'h0, ST_OK,       0);
    add_row(CMD_REMOVE, 2,  32'h0,         0,  0, 32'h0, ST_OK,       0);
    add_row(CMD_READ,   1,  32'h0,         0,  0, 32'h0, ST_OK,       0);
    add_row(CMD_APPEND, 0,  32'hAAAA_AAAA, 0,  0, 32'h0, ST_OK,       0);

    wait (rst_n === 1'b1);
    @(negedge clk);
    foreach (directed_rows[i])
      send_command(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);

    for (phase = 0; phase < PHASES; phase++) begin
      // The sender pauses until every expected item has come back.
      in_tvalid <= 1'b0;
      @(negedge clk);
      while (pending_results.size() != 0) @(negedge clk);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      // Long receiver hold-off while the sender keeps offering items.
      if (phase == 0 || phase == 6) hold_request = LONG_HOLD;
      for (n = 0; n < PHASE_ITEMS; n++)
        send_command(random_command(phase % 3), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
